@@ rtl/core/sorted_priority_insert_queue_top_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the sorted priority insert queue
// Concurrent check wrappers; defining NO_ASSERTIONS compiles them away.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_INSERT_QUEUE_TOP_MACROS_SVH
`define SORTED_PRIORITY_INSERT_QUEUE_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// checked outside reset
`define SPQ_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// checked on every edge, reset included
`define SPQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SPQ_ASSERT(lbl, clk, rstn, prop, msg)
`define SPQ_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

@@ rtl/core/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// Sorted priority insert queue package
// Sizes, result codes, controller states and command/status structs.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DEPTH  = 16;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int PRIO_W = 16;
    localparam int DATA_W = 32;
    localparam int KIND_W = 2;

    typedef enum logic {
        ACT_INSERT  = 1'b0,
        ACT_DISPLAY = 1'b1
    } t_action;

    typedef enum logic [KIND_W-1:0] {
        KIND_ACCEPT = 2'd0,
        KIND_FULL   = 2'd1,
        KIND_DATA   = 2'd2,
        KIND_EMPTY  = 2'd3
    } t_kind;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_DISP = 1'b1
    } t_state;

    typedef struct packed {
        logic  ins;
        logic  out_ld;
        t_kind out_kind;
        logic  idx_clr;
        logic  idx_inc;
    } t_dp_cmd;

    typedef struct packed {
        logic full;
        logic empty;
        logic idx_last;
        logic out_free;
    } t_dp_sts;

endpackage

@@ rtl/core/spq_in_if.sv @@
// ----------------------------------------------------------------------------
// Queue request channel
// Valid/ready channel carrying one insert or display request word.
// ----------------------------------------------------------------------------
interface spq_in_if;

    logic                                   valid;
    logic                                   ready;
    logic                                   action;
    logic signed [spq_pkg::PRIO_W-1:0]      priority_req;
    logic signed [spq_pkg::DATA_W-1:0]      value;

    modport source (output valid, output action, output priority_req, output value,
                    input ready);
    modport sink   (input valid, input action, input priority_req, input value,
                    output ready);

endinterface

@@ rtl/core/spq_out_if.sv @@
// ----------------------------------------------------------------------------
// Queue result channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
interface spq_out_if;

    logic                                   valid;
    logic                                   ready;
    logic        [spq_pkg::KIND_W-1:0]      kind;
    logic signed [spq_pkg::DATA_W-1:0]      data;
    logic                                   last;

    modport source (output valid, output kind, output data, output last, input ready);
    modport sink   (input valid, input kind, input data, input last, output ready);

endinterface

@@ rtl/core/spq_datapath.sv @@
// ----------------------------------------------------------------------------
// Queue datapath
// Sorted entry row with parallel compare and shift insert, entry count,
// display read index and the output word register.
// ----------------------------------------------------------------------------
`include "sorted_priority_insert_queue_top_macros.svh"

module spq_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  spq_pkg::t_dp_cmd                    i_cmd,
    output spq_pkg::t_dp_sts                    o_sts,
    input  logic signed [spq_pkg::PRIO_W-1:0]   i_priority_req,
    input  logic signed [spq_pkg::DATA_W-1:0]   i_value,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output spq_pkg::t_kind                      o_kind,
    output logic signed [spq_pkg::DATA_W-1:0]   o_data,
    output logic                                o_last
);

    logic signed [spq_pkg::DATA_W-1:0]  r_val   [spq_pkg::DEPTH];
    logic signed [spq_pkg::PRIO_W-1:0]  r_prio  [spq_pkg::DEPTH];
    logic signed [spq_pkg::DATA_W-1:0]  n_val   [spq_pkg::DEPTH];
    logic signed [spq_pkg::PRIO_W-1:0]  n_prio  [spq_pkg::DEPTH];
    logic signed [spq_pkg::DATA_W-1:0]  sh_val  [spq_pkg::DEPTH];
    logic signed [spq_pkg::PRIO_W-1:0]  sh_prio [spq_pkg::DEPTH];
    logic        [spq_pkg::DEPTH-1:0]   lt;
    logic        [spq_pkg::DEPTH-1:0]   lt_prev;

    logic [spq_pkg::CNT_W-1:0]          r_count;
    logic [spq_pkg::CNT_W-1:0]          n_count;
    logic [spq_pkg::IDX_W-1:0]          r_idx;
    logic [spq_pkg::IDX_W-1:0]          n_idx;

    logic                               r_out_valid;
    logic                               n_out_valid;
    spq_pkg::t_kind                     r_kind;
    logic signed [spq_pkg::DATA_W-1:0]  r_data;
    logic                               r_last;
    logic signed [spq_pkg::DATA_W-1:0]  n_data;
    logic                               n_last;

    // entries below the insert point (row is sorted, so this is a prefix)
    always_comb begin
        for (int i = 0; i < spq_pkg::DEPTH; i++) begin
            lt[i] = (spq_pkg::CNT_W'(i) < r_count) && (r_prio[i] < i_priority_req);
        end
        lt_prev = {lt[spq_pkg::DEPTH-2:0], 1'b1};
    end

    always_comb begin
        sh_val[0]  = r_val[0];
        sh_prio[0] = r_prio[0];
        for (int i = 1; i < spq_pkg::DEPTH; i++) begin
            sh_val[i]  = r_val[i-1];
            sh_prio[i] = r_prio[i-1];
        end
        for (int i = 0; i < spq_pkg::DEPTH; i++) begin
            if (lt[i]) begin
                n_val[i]  = r_val[i];
                n_prio[i] = r_prio[i];
            end else if (lt_prev[i]) begin
                n_val[i]  = i_value;
                n_prio[i] = i_priority_req;
            end else begin
                n_val[i]  = sh_val[i];
                n_prio[i] = sh_prio[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins) begin
            r_val  <= n_val;
            r_prio <= n_prio;
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.ins) begin
            n_count = r_count + spq_pkg::CNT_W'(1);
        end
        n_idx = r_idx;
        if (i_cmd.idx_clr) begin
            n_idx = '0;
        end else if (i_cmd.idx_inc) begin
            n_idx = r_idx + spq_pkg::IDX_W'(1);
        end
    end

    always_comb begin
        o_sts.full     = (r_count == spq_pkg::CNT_W'(spq_pkg::DEPTH));
        o_sts.empty    = (r_count == '0);
        o_sts.idx_last = ((spq_pkg::CNT_W'(r_idx) + spq_pkg::CNT_W'(1)) == r_count);
        o_sts.out_free = !r_out_valid || i_out_ready;
    end

    always_comb begin
        n_out_valid = r_out_valid && !i_out_ready;
        if (i_cmd.out_ld) begin
            n_out_valid = 1'b1;
        end
        n_data = '0;
        n_last = 1'b1;
        if (i_cmd.out_kind == spq_pkg::KIND_DATA) begin
            n_data = r_val[r_idx];
            n_last = o_sts.idx_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            r_kind <= i_cmd.out_kind;
            r_data <= n_data;
            r_last <= n_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_data      = r_data;
    assign o_last      = r_last;

    `SPQ_ASSERT_ALWAYS(a_count_rst, i_clk, !i_rst_n |=> (r_count == '0), "count not cleared")
    `SPQ_ASSERT(a_count_max, i_clk, i_rst_n, r_count <= spq_pkg::CNT_W'(spq_pkg::DEPTH), "count over depth")
    `SPQ_ASSERT(a_ins_inc, i_clk, i_rst_n, i_cmd.ins |=> (r_count == $past(r_count) + spq_pkg::CNT_W'(1)), "insert did not bump count")

endmodule

@@ rtl/core/spq_ctrl.sv @@
// ----------------------------------------------------------------------------
// Queue controller
// Accepts requests, issues insert and output loads, sequences displays.
// ----------------------------------------------------------------------------
`include "sorted_priority_insert_queue_top_macros.svh"

module spq_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_action,
    output logic                o_in_ready,
    input  spq_pkg::t_dp_sts    i_sts,
    output spq_pkg::t_dp_cmd    o_cmd
);

    spq_pkg::t_state r_state;
    spq_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_in_ready     = 1'b0;
        o_cmd.ins      = 1'b0;
        o_cmd.out_ld   = 1'b0;
        o_cmd.out_kind = spq_pkg::KIND_ACCEPT;
        o_cmd.idx_clr  = 1'b0;
        o_cmd.idx_inc  = 1'b0;
        unique case (r_state)
            spq_pkg::S_IDLE: begin
                o_in_ready = i_sts.out_free;
                if (i_in_valid && i_sts.out_free) begin
                    if (i_action == spq_pkg::ACT_INSERT) begin
                        o_cmd.out_ld   = 1'b1;
                        o_cmd.ins      = !i_sts.full;
                        o_cmd.out_kind = i_sts.full ? spq_pkg::KIND_FULL
                                                    : spq_pkg::KIND_ACCEPT;
                    end else if (i_sts.empty) begin
                        o_cmd.out_ld   = 1'b1;
                        o_cmd.out_kind = spq_pkg::KIND_EMPTY;
                    end else begin
                        o_cmd.idx_clr  = 1'b1;
                        n_state        = spq_pkg::S_DISP;
                    end
                end
            end
            spq_pkg::S_DISP: begin
                o_cmd.out_kind = spq_pkg::KIND_DATA;
                if (i_sts.out_free) begin
                    o_cmd.out_ld  = 1'b1;
                    o_cmd.idx_inc = 1'b1;
                    if (i_sts.idx_last) begin
                        n_state = spq_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = spq_pkg::S_IDLE;
            end
        endcase
    end

    `SPQ_ASSERT(a_disp_no_accept, i_clk, i_rst_n, (r_state == spq_pkg::S_DISP) |-> !o_in_ready, "request taken mid display")
    `SPQ_ASSERT(a_disp_end, i_clk, i_rst_n, (r_state == spq_pkg::S_DISP && i_sts.out_free && i_sts.idx_last) |=> (r_state == spq_pkg::S_IDLE), "display did not end")

endmodule

@@ rtl/core/sorted_priority_insert_queue_top.sv @@
// ----------------------------------------------------------------------------
// Sorted priority insert queue
// Bounded queue kept in ascending priority order; equal priorities newest
// first. Inserts into a full queue are dropped and reported.
//
//  channel   dir   port   word
//  request   in    i_in   action, priority_req, value
//  result    out   o_out  kind, data, last
//
// Insert: one result word; compare and shift run over the whole row.
// Display: the read index is cleared first, then one word per stored entry is
// read through the single row read port; an empty queue gives one word.
// Reset clears the entry count and control state, not the entries. A stalled
// result holds its register and blocks the next request; display pauses while
// o_out is stalled.
// ----------------------------------------------------------------------------
module sorted_priority_insert_queue_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    spq_in_if.sink      i_in,
    spq_out_if.source   o_out
);

    spq_pkg::t_dp_cmd   cmd;
    spq_pkg::t_dp_sts   sts;
    spq_pkg::t_kind     kind;

    spq_ctrl u_ctl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_action   (i_in.action),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    spq_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_priority_req (i_in.priority_req),
        .i_value        (i_in.value),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_kind         (kind),
        .o_data         (o_out.data),
        .o_last         (o_out.last)
    );

    assign o_out.kind = kind;

endmodule
